// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL files that carry checks.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_IMPLY(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Condition that holds on every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, ck, rs, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond)) else $error(msg);

`endif

// ===== rtl/pfb_pkg.sv =====
// Shared types and operation codes of the page framebuffer raster block.
// No dependencies.
package pfb_pkg;

  // Operation codes
  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_FILL   = 3'd1;
  localparam logic [2:0] OP_INVERT = 3'd2;
  localparam logic [2:0] OP_BITMAP = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;
  localparam logic [2:0] OP_FLUSH  = 3'd5;

  // Classified command, passed from the front end to the back end
  typedef struct packed {
    logic [2:0]  op;
    logic        empty;      // zero width or zero height
    logic [6:0]  x;
    logic [5:0]  y;
    logic [7:0]  w;
    logic [6:0]  h;
    logic [7:0]  pb;
    logic [4:0]  ep;         // last page the rectangle reaches
    logic [4:0]  p_last;     // last page to walk, clipped to the frame
    logic [8:0]  col_last;   // last column to walk, clipped to the frame
    logic        walk_none;  // rectangle lies fully outside the frame
    logic [3:0]  need;       // dirty page count the rectangle needs, capped
    logic [11:0] total;      // bitmap stream length in bytes
    logic [4:0]  rows;       // source page rows of a bitmap
    logic        read_ok;    // read address lies inside the frame
    logic [2:0]  rpage;
    logic [6:0]  rcol;
  } pfb_cmd_t;

endpackage

// ===== rtl/pfb_if.sv =====
// Valid/ready channels of the page framebuffer block: command in, result out.
// No dependencies.
interface pfb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [6:0] rect_x;
  logic [5:0] rect_y;
  logic [7:0] rect_w;
  logic [6:0] rect_h;
  logic [7:0] pixel_byte;
  logic [2:0] read_page;
  logic [6:0] read_column;

  modport source (output valid, operation, rect_x, rect_y, rect_w, rect_h, pixel_byte,
                  read_page, read_column, input ready);
  modport sink (input valid, operation, rect_x, rect_y, rect_w, rect_h, pixel_byte,
                read_page, read_column, output ready);
endinterface

interface pfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [3:0] dirty_pages;
  logic       flush_pending;

  modport source (output valid, read_data, dirty_pages, flush_pending, input ready);
  modport sink (input valid, read_data, dirty_pages, flush_pending, output ready);
endinterface

// ===== rtl/page_framebuffer_raster_ops_top.sv =====
// Each item is executed in turn: fill and invert read each byte walked from the frame RAM
// and write it back; clear rewrites the whole frame; bitmap rederives its row and column
// with a divider when the width changes mid-stream. The back end takes one item at a time,
// and a 2-entry queue holds two more; result backpressure stalls it.
// Reset is synchronous; afterwards a clear of the whole frame holds ready low.
`include "assert_macros.svh"

module page_framebuffer_raster_ops_top #(
  parameter int SCREEN_WIDTH = 128,
  parameter int PAGE_COUNT   = 8
) (
  input  logic      clk,
  input  logic      rst,
  pfb_in_if.sink    req,
  pfb_out_if.source rsp
);
  import pfb_pkg::*;

  localparam int DIRTY_CAP = (PAGE_COUNT > 15) ? 15 : PAGE_COUNT;

  logic     init_busy;
  logic     push;
  logic     pop;
  logic     q_full;
  logic     q_empty;
  pfb_cmd_t f_cmd;
  pfb_cmd_t q_head;

  pfb_front #(.SCREEN_WIDTH(SCREEN_WIDTH), .PAGE_COUNT(PAGE_COUNT)) u_front (
    .req(req), .init_busy(init_busy), .q_full(q_full), .push(push), .cmd(f_cmd)
  );

  pfb_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .din(f_cmd), .pop(pop), .dout(q_head),
    .full(q_full), .empty(q_empty)
  );

  pfb_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .PAGE_COUNT(PAGE_COUNT)) u_back (
    .clk(clk), .rst(rst), .q_empty(q_empty), .q_head(q_head), .pop(pop),
    .init_busy(init_busy), .rsp(rsp)
  );

  // Checks
  `ASSERT_IMPLY(a_dirty_cap, clk, rst, rsp.valid, rsp.dirty_pages <= 4'(DIRTY_CAP), "dirty count above cap")
  `ASSERT_IMPLY(a_clean_flushed, clk, rst, rsp.valid && !rsp.flush_pending, rsp.dirty_pages == 4'd0, "dirty pages without pending flag")
  `ASSERT_IMPLY(a_init_quiet, clk, rst, init_busy, !rsp.valid && !req.ready, "activity during frame clear")
  `ASSERT_ALWAYS(a_queue_sane, clk, rst, !(q_full && q_empty), "queue both full and empty")
endmodule

// ===== rtl/pfb_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/pfb_front.sv =====
// Front end: accepts command items and classifies them into queue entries.
// Depends on pfb_pkg and pfb_in_if.
module pfb_front #(
  parameter int SCREEN_WIDTH = 128,
  parameter int PAGE_COUNT   = 8
) (
  pfb_in_if.sink            req,
  input  logic              init_busy,
  input  logic              q_full,
  output logic              push,
  output pfb_pkg::pfb_cmd_t cmd
);
  import pfb_pkg::*;

  localparam int DIRTY_CAP = (PAGE_COUNT > 15) ? 15 : PAGE_COUNT;

  logic [7:0]  h_round;
  logic [12:0] total_full;
  logic [7:0]  bottom;
  logic [4:0]  need_full;
  logic [8:0]  col_end;

  // No items while the queue is full or the frame is being cleared after reset
  assign req.ready = !q_full && !init_busy;
  assign push      = req.valid && req.ready;

  // Geometry of the rectangle and the read address check
  always_comb begin
    h_round    = {1'b0, req.rect_h} + 8'd7;
    total_full = {5'b0, req.rect_w} * {8'b0, h_round[7:3]};
    bottom     = {2'b0, req.rect_y} + {1'b0, req.rect_h} - 8'd1;
    need_full  = bottom[7:3] + 5'd1;
    col_end    = {2'b0, req.rect_x} + {1'b0, req.rect_w} - 9'd1;

    cmd.op       = req.operation;
    cmd.empty    = (req.rect_w == 8'd0) || (req.rect_h == 7'd0);
    cmd.x        = req.rect_x;
    cmd.y        = req.rect_y;
    cmd.w        = req.rect_w;
    cmd.h        = req.rect_h;
    cmd.pb       = req.pixel_byte;
    cmd.ep       = bottom[7:3];
    cmd.p_last   = (bottom[7:3] < 5'(PAGE_COUNT)) ? bottom[7:3] : 5'(PAGE_COUNT - 1);
    cmd.col_last = (col_end < 9'(SCREEN_WIDTH)) ? col_end : 9'(SCREEN_WIDTH - 1);
    cmd.walk_none = ({2'b0, req.rect_x} >= 9'(SCREEN_WIDTH)) ||
                    ({2'b0, req.rect_y[5:3]} >= 5'(PAGE_COUNT));
    cmd.need     = (need_full > 5'(DIRTY_CAP)) ? 4'(DIRTY_CAP) : need_full[3:0];
    cmd.total    = total_full[11:0];
    cmd.rows     = h_round[7:3];
    cmd.read_ok  = ({2'b0, req.read_page} < 5'(PAGE_COUNT)) &&
                   ({2'b0, req.read_column} < 9'(SCREEN_WIDTH));
    cmd.rpage    = req.read_page;
    cmd.rcol     = req.read_column;
  end
endmodule

// ===== rtl/pfb_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on pfb_pkg.
module pfb_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pfb_pkg::pfb_cmd_t din,
  input  logic              pop,
  output pfb_pkg::pfb_cmd_t dout,
  output logic              full,
  output logic              empty
);
  import pfb_pkg::*;

  pfb_cmd_t   entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign dout  = entry[rd_ptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= din;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end
endmodule

// ===== rtl/pfb_back.sv =====
// Back end: executes queued commands on the frame store and drives results.
// Depends on pfb_pkg, pfb_out_if and pfb_ram.
module pfb_back #(
  parameter int SCREEN_WIDTH = 128,
  parameter int PAGE_COUNT   = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  pfb_pkg::pfb_cmd_t q_head,
  output logic              pop,
  output logic              init_busy,
  pfb_out_if.source         rsp
);
  import pfb_pkg::*;

  localparam int FRAME_DEPTH = SCREEN_WIDTH * PAGE_COUNT;
  localparam int AW          = $clog2(FRAME_DEPTH);
  localparam int CW          = $clog2(SCREEN_WIDTH);
  localparam int DIRTY_CAP   = (PAGE_COUNT > 15) ? 15 : PAGE_COUNT;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_WRD   = 4'd3;
  localparam logic [3:0] S_WWR   = 4'd4;
  localparam logic [3:0] S_BCHK  = 4'd5;
  localparam logic [3:0] S_BDIV  = 4'd6;
  localparam logic [3:0] S_BRD   = 4'd7;
  localparam logic [3:0] S_BWR   = 4'd8;
  localparam logic [3:0] S_BRD2  = 4'd9;
  localparam logic [3:0] S_BWR2  = 4'd10;
  localparam logic [3:0] S_BDONE = 4'd11;
  localparam logic [3:0] S_RRD   = 4'd12;
  localparam logic [3:0] S_RCAP  = 4'd13;
  localparam logic [3:0] S_RES   = 4'd14;

  logic [3:0]    state;
  logic [AW-1:0] sweep;
  pfb_cmd_t      cmd;
  logic [9:0]    n;
  logic [9:0]    k;
  logic [7:0]    c;
  logic [7:0]    last_w;
  logic [3:0]    div_cnt;
  logic [4:0]    wp;
  logic [8:0]    wc;
  logic [3:0]    dirty;
  logic          pending;
  logic [7:0]    rd_hold;
  logic          out_valid;
  logic [7:0]    out_read;
  logic [3:0]    out_dirty;
  logic          out_pend;

  logic          f_we;
  logic [AW-1:0] f_waddr;
  logic [7:0]    f_wdata;
  logic [AW-1:0] f_raddr;
  logic [7:0]    f_rdata;
  logic          p_we;
  logic [CW-1:0] p_waddr;
  logic [7:0]    p_wdata;
  logic [CW-1:0] p_raddr;
  logic [7:0]    p_rdata;

  logic [2:0]  off;
  logic [3:0]  rsh;
  logic [10:0] bpage;
  logic [10:0] bpage1;
  logic        bpage_ok;
  logic        bpage1_ok;
  logic [8:0]  bcol;
  logic [7:0]  bval;
  logic        second;
  logic        n_restart;
  logic [10:0] n1;
  logic [8:0]  rem_t;
  logic        rem_ge;

  // Bits of a page that lie within pixel rows [top, top + height)
  function automatic logic [7:0] page_mask(input logic [4:0] pg, input logic [5:0] top,
                                           input logic [6:0] height);
    logic [7:0] m;
    logic [7:0] row;
    logic [7:0] lim;
    lim = {2'b0, top} + {1'b0, height};
    for (int b = 0; b < 8; b++) begin
      row  = {pg, 3'(b)};
      m[b] = (row >= {2'b0, top}) && (row < lim);
    end
    return m;
  endfunction

  function automatic logic [AW-1:0] faddr(input logic [4:0] pg, input logic [8:0] cl);
    return AW'(int'(pg) * SCREEN_WIDTH + int'(cl));
  endfunction

  function automatic logic [7:0] merge(input logic [7:0] old, input logic [7:0] val,
                                       input logic [7:0] m);
    return (old & ~m) | (val & m);
  endfunction

  pfb_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_frame (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_rdata)
  );

  pfb_ram #(.WIDTH(8), .DEPTH(SCREEN_WIDTH)) u_prev (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata)
  );

  assign pop       = (state == S_IDLE) && !q_empty;
  assign init_busy = (state == S_INIT);

  assign rsp.valid         = out_valid;
  assign rsp.read_data     = out_read;
  assign rsp.dirty_pages   = out_dirty;
  assign rsp.flush_pending = out_pend;

  // Bitmap placement from the stream position
  always_comb begin
    off       = cmd.y[2:0];
    rsh       = 4'd8 - {1'b0, off};
    bpage     = {8'b0, cmd.y[5:3]} + {1'b0, k};
    bpage1    = bpage + 11'd1;
    bpage_ok  = bpage < 11'(PAGE_COUNT);
    bpage1_ok = bpage1 < 11'(PAGE_COUNT);
    bcol      = {2'b0, cmd.x} + {1'b0, c};
    bval      = cmd.pb << off;
    if (k != 10'd0 && off != 3'd0) begin
      bval = bval | (p_rdata >> rsh);
    end
    second    = (({1'b0, k} + 11'd1) == {6'b0, cmd.rows}) &&
                (bpage1 <= {6'b0, cmd.ep}) && (off != 3'd0);
    n_restart = {2'b0, n} >= cmd.total;
    n1        = {1'b0, n} + 11'd1;
    rem_t     = {c, k[9]};
    rem_ge    = rem_t >= {1'b0, cmd.w};
  end

  // Memory port control
  always_comb begin
    f_we    = 1'b0;
    f_waddr = sweep;
    f_wdata = 8'd0;
    f_raddr = faddr(wp, wc);
    p_we    = 1'b0;
    p_waddr = c[CW-1:0];
    p_wdata = cmd.pb;
    p_raddr = c[CW-1:0];
    case (state)
      S_INIT, S_CLR: begin
        f_we = 1'b1;
      end
      S_WWR: begin
        f_we    = 1'b1;
        f_waddr = faddr(wp, wc);
        f_wdata = merge(f_rdata, (cmd.op == OP_INVERT) ? ~f_rdata : cmd.pb,
                        page_mask(wp, cmd.y, cmd.h));
      end
      S_BRD: begin
        f_raddr = faddr(bpage[4:0], bcol);
      end
      S_BWR: begin
        f_we    = bpage_ok;
        f_waddr = faddr(bpage[4:0], bcol);
        f_wdata = merge(f_rdata, bval, page_mask(bpage[4:0], cmd.y, cmd.h));
        p_we    = 1'b1;
      end
      S_BRD2: begin
        f_raddr = faddr(bpage1[4:0], bcol);
      end
      S_BWR2: begin
        f_we    = bpage1_ok;
        f_waddr = faddr(bpage1[4:0], bcol);
        f_wdata = merge(f_rdata, cmd.pb >> rsh, page_mask(bpage1[4:0], cmd.y, cmd.h));
      end
      S_RRD: begin
        f_raddr = faddr({2'b0, cmd.rpage}, {2'b0, cmd.rcol});
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      sweep     <= '0;
      n         <= 10'd0;
      k         <= 10'd0;
      c         <= 8'd0;
      last_w    <= 8'd0;
      dirty     <= 4'd0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          sweep <= sweep + AW'(1);
          if (sweep == AW'(FRAME_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            cmd     <= q_head;
            rd_hold <= 8'd0;
            wp      <= {2'b0, q_head.y[5:3]};
            wc      <= {2'b0, q_head.x};
            state   <= S_RES;
            case (q_head.op)
              OP_CLEAR: begin
                n       <= 10'd0;
                k       <= 10'd0;
                c       <= 8'd0;
                dirty   <= 4'(DIRTY_CAP);
                pending <= 1'b1;
                sweep   <= '0;
                state   <= S_CLR;
              end
              OP_FILL, OP_INVERT: begin
                n <= 10'd0;
                k <= 10'd0;
                c <= 8'd0;
                if (!q_head.empty) begin
                  pending <= 1'b1;
                  if (q_head.need > dirty) begin
                    dirty <= q_head.need;
                  end
                  if (!q_head.walk_none) begin
                    state <= S_WRD;
                  end
                end
              end
              OP_BITMAP: begin
                if (q_head.empty) begin
                  n <= 10'd0;
                  k <= 10'd0;
                  c <= 8'd0;
                end else begin
                  pending <= 1'b1;
                  if (q_head.need > dirty) begin
                    dirty <= q_head.need;
                  end
                  state <= S_BCHK;
                end
              end
              OP_READ: begin
                state <= S_RRD;
              end
              OP_FLUSH: begin
                n       <= 10'd0;
                k       <= 10'd0;
                c       <= 8'd0;
                dirty   <= 4'd0;
                pending <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_CLR: begin
          sweep <= sweep + AW'(1);
          if (sweep == AW'(FRAME_DEPTH - 1)) begin
            state <= S_RES;
          end
        end
        S_WRD: begin
          state <= S_WWR;
        end
        // Advance over columns, then pages
        S_WWR: begin
          state <= S_WRD;
          if (wc == cmd.col_last) begin
            if (wp == cmd.p_last) begin
              state <= S_RES;
            end else begin
              wp <= wp + 5'd1;
              wc <= {2'b0, cmd.x};
            end
          end else begin
            wc <= wc + 9'd1;
          end
        end
        // Restart a stale stream; rederive row and column if the width changed
        S_BCHK: begin
          last_w <= cmd.w;
          state  <= S_BRD;
          if (n_restart) begin
            n <= 10'd0;
            k <= 10'd0;
            c <= 8'd0;
          end else if (n != 10'd0 && cmd.w != last_w) begin
            k       <= n;
            c       <= 8'd0;
            div_cnt <= 4'd0;
            state   <= S_BDIV;
          end
        end
        // Restoring division, one quotient bit a cycle
        S_BDIV: begin
          c       <= rem_ge ? 8'(rem_t - {1'b0, cmd.w}) : rem_t[7:0];
          k       <= {k[8:0], rem_ge};
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == 4'd9) begin
            state <= S_BRD;
          end
        end
        S_BRD: begin
          state <= (bcol < 9'(SCREEN_WIDTH)) ? S_BWR : S_BDONE;
        end
        S_BWR: begin
          state <= second ? S_BRD2 : S_BDONE;
        end
        S_BRD2: begin
          state <= S_BWR2;
        end
        S_BWR2: begin
          state <= S_BDONE;
        end
        S_BDONE: begin
          state <= S_RES;
          if (n1[10] || {1'b0, n1} >= cmd.total) begin
            n <= 10'd0;
            k <= 10'd0;
            c <= 8'd0;
          end else begin
            n <= n1[9:0];
            if (({1'b0, c} + 9'd1) == {1'b0, cmd.w}) begin
              c <= 8'd0;
              k <= k + 10'd1;
            end else begin
              c <= c + 8'd1;
            end
          end
        end
        S_RRD: begin
          state <= S_RCAP;
        end
        S_RCAP: begin
          rd_hold <= cmd.read_ok ? f_rdata : 8'd0;
          state   <= S_RES;
        end
        // Hand the result to the output register
        S_RES: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state == S_RES && (!out_valid || rsp.ready)) begin
      out_read  <= rd_hold;
      out_dirty <= dirty;
      out_pend  <= pending;
    end
  end
endmodule
